// ===== hdl/longest_prefix_match_router_top_defines.svh =====
// Assertion macros shared by the routing table checker.
`ifndef LONGEST_PREFIX_MATCH_ROUTER_TOP_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lpm_pkg.sv =====
// Shared types, constants and helpers of the longest prefix match router.
package lpm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF    = 32;
  localparam int unsigned NUM_INTERFACES_DEF = 16;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned IFC_W    = 4;
  localparam int unsigned TTL_W    = 8;
  localparam int unsigned STATUS_W = 3;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);
  localparam logic [TTL_W-1:0] TTL_MIN_FWD = TTL_W'(2);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_FULL        = 3'd2,
    ST_FORWARDED   = 3'd3,
    ST_NO_ROUTE    = 3'd4,
    ST_TTL_EXPIRED = 3'd5
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic              hop_valid;
    logic [ADDR_W-1:0] hop;
    logic [IFC_W-1:0]  ifc;
  } entry_t;

  typedef struct packed {
    logic dup;      // all route fields equal
    logic shorter;  // stored length below the new one
    logic hit;      // masked destination equals stored prefix
    logic ifc_ok;   // stored interface exists
  } cmp_t;

  // High-order mask of len ones; len is at most 32 here.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ===== hdl/longest_prefix_match_router_top.sv =====
// Top level of the IPv4 longest prefix match router.
// A lookup scans the entries in order until the first hit or the end of the table.
// An add scans for its slot, shifts the entries from there down and writes the new route.
// One transaction at a time: the single table read port and compare unit set the pace.
// The result strobe done_o is high for one cycle; the receiver cannot stall.
// Reset empties the table (entry count to zero) and returns the sequencer to idle.
module longest_prefix_match_router_top #(
  parameter int unsigned TABLE_DEPTH    = lpm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NUM_INTERFACES = lpm_pkg::NUM_INTERFACES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          operation_i,
  input  logic [lpm_pkg::ADDR_W-1:0]    address_i,
  input  logic [lpm_pkg::LEN_W-1:0]     prefix_len_i,
  input  logic                          hop_valid_i,
  input  logic [lpm_pkg::ADDR_W-1:0]    hop_address_i,
  input  logic [lpm_pkg::IFC_W-1:0]     interface_index_i,
  input  logic [lpm_pkg::TTL_W-1:0]     time_to_live_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [lpm_pkg::STATUS_W-1:0]  status_o,
  output logic [lpm_pkg::IFC_W-1:0]     out_interface_o,
  output logic [lpm_pkg::ADDR_W-1:0]    out_hop_o,
  output logic [lpm_pkg::TTL_W-1:0]     new_ttl_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // Latched transaction key, presented to the compare unit every cycle.
  lpm_pkg::entry_t key;
  // Entry read back from the table, in the cycle after its address.
  lpm_pkg::entry_t rdata;
  // Compare results on the entry currently read.
  lpm_pkg::cmp_t   cmp;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  lpm_pkg::entry_t mem_wdata;

  // Sequencer: walk the table in order, longest prefix first. A lookup stops
  // at the first hit; an add stops at a duplicate or at the first shorter
  // entry (else at the end), then, unless the table is full, shifts the tail
  // down one slot at a time and writes the new route into the gap.
  lpm_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .prefix_len_i      (prefix_len_i),
    .hop_valid_i       (hop_valid_i),
    .hop_address_i     (hop_address_i),
    .interface_index_i (interface_index_i),
    .time_to_live_i    (time_to_live_i),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .status_o          (status_o),
    .out_interface_o   (out_interface_o),
    .out_hop_o         (out_hop_o),
    .new_ttl_o         (new_ttl_o),
    .key_o             (key),
    .cmp_i             (cmp),
    .rdata_i           (rdata),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr)
  );

  // Shared compare unit: one mask-and-compare plus the duplicate and length
  // tests, reused for every entry of the scan.
  lpm_cmp #(
    .NUM_INTERFACES (NUM_INTERFACES)
  ) u_cmp (
    .key_i (key),
    .ent_i (rdata),
    .cmp_o (cmp)
  );

  // Route storage; only entries below the entry count are ever used.
  lpm_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== hdl/lpm_table.sv =====
// Route table storage: one write port, one registered read port.
module lpm_table #(
  parameter int unsigned TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  lpm_pkg::entry_t   wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output lpm_pkg::entry_t   rdata_o
);

  lpm_pkg::entry_t mem_q [TABLE_DEPTH];
  lpm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lpm_cmp.sv =====
// Shared compare unit: match, duplicate and ordering tests on one entry.
module lpm_cmp #(
  parameter int unsigned NUM_INTERFACES = lpm_pkg::NUM_INTERFACES_DEF
) (
  input  lpm_pkg::entry_t key_i,
  input  lpm_pkg::entry_t ent_i,
  output lpm_pkg::cmp_t   cmp_o
);

  logic [lpm_pkg::ADDR_W-1:0] mask;

  assign mask = lpm_pkg::len_mask(ent_i.length);

  assign cmp_o.dup     = (key_i == ent_i);
  assign cmp_o.shorter = (ent_i.length < key_i.length);
  assign cmp_o.hit     = ((key_i.prefix & mask) == ent_i.prefix);
  assign cmp_o.ifc_ok  = (32'(ent_i.ifc) < 32'(NUM_INTERFACES));

endmodule

// ===== hdl/lpm_seq.sv =====
// Sequencer: scans, shifts and inserts table entries, and forms the result.
module lpm_seq #(
  parameter int unsigned TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          operation_i,
  input  logic [lpm_pkg::ADDR_W-1:0]    address_i,
  input  logic [lpm_pkg::LEN_W-1:0]     prefix_len_i,
  input  logic                          hop_valid_i,
  input  logic [lpm_pkg::ADDR_W-1:0]    hop_address_i,
  input  logic [lpm_pkg::IFC_W-1:0]     interface_index_i,
  input  logic [lpm_pkg::TTL_W-1:0]     time_to_live_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [lpm_pkg::STATUS_W-1:0]  status_o,
  output logic [lpm_pkg::IFC_W-1:0]     out_interface_o,
  output logic [lpm_pkg::ADDR_W-1:0]    out_hop_o,
  output logic [lpm_pkg::TTL_W-1:0]     new_ttl_o,
  output lpm_pkg::entry_t               key_o,
  input  lpm_pkg::cmp_t                 cmp_i,
  input  lpm_pkg::entry_t               rdata_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output lpm_pkg::entry_t               mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_PLACE,
    S_MOVE,
    S_MOVE_WR
  } state_e;

  state_e                        state_q;
  logic                          op_q;
  lpm_pkg::entry_t               key_q;
  logic [lpm_pkg::TTL_W-1:0]     ttl_q;
  logic [CW-1:0]                 count_q;
  logic [CW-1:0]                 idx_q;
  logic [CW-1:0]                 pos_q;
  logic                          done_q;
  lpm_pkg::status_e              status_q;
  logic [lpm_pkg::IFC_W-1:0]     ifc_q;
  logic [lpm_pkg::ADDR_W-1:0]    hop_q;
  logic [lpm_pkg::TTL_W-1:0]     nttl_q;
  logic [CW-1:0]                 idx_dec;

  assign idx_dec = idx_q - CW'(1);

  // Memory port control.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = rdata_i;
    mem_raddr_o = idx_q[AW-1:0];
    case (state_q)
      S_MOVE: begin
        mem_raddr_o = idx_dec[AW-1:0];
        if (idx_q == pos_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = key_q;
        end
      end
      S_MOVE_WR: begin
        mem_we_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= lpm_pkg::OP_ADD;
      key_q    <= '0;
      ttl_q    <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      done_q   <= 1'b0;
      status_q <= lpm_pkg::ST_ADDED;
      ifc_q    <= '0;
      hop_q    <= '0;
      nttl_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q            <= operation_i;
            key_q.prefix    <= address_i;
            key_q.length    <= (prefix_len_i > lpm_pkg::MAX_LEN) ?
                               lpm_pkg::MAX_LEN : prefix_len_i;
            key_q.hop_valid <= hop_valid_i;
            key_q.hop       <= hop_valid_i ? hop_address_i : '0;
            key_q.ifc       <= interface_index_i;
            ttl_q           <= time_to_live_i;
            idx_q           <= '0;
            pos_q           <= count_q;
            state_q         <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_q == count_q) begin
            if (op_q == lpm_pkg::OP_ADD) begin
              state_q <= S_PLACE;
            end else begin
              done_q   <= 1'b1;
              status_q <= lpm_pkg::ST_NO_ROUTE;
              ifc_q    <= '0;
              hop_q    <= '0;
              nttl_q   <= '0;
              state_q  <= S_IDLE;
            end
          end else begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (op_q == lpm_pkg::OP_ADD) begin
            if (cmp_i.dup) begin
              done_q   <= 1'b1;
              status_q <= lpm_pkg::ST_DUPLICATE;
              ifc_q    <= '0;
              hop_q    <= '0;
              nttl_q   <= '0;
              state_q  <= S_IDLE;
            end else if (cmp_i.shorter) begin
              pos_q   <= idx_q;
              state_q <= S_PLACE;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= S_SCAN;
            end
          end else if (cmp_i.hit) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
            if (!cmp_i.ifc_ok || ttl_q < lpm_pkg::TTL_MIN_FWD) begin
              status_q <= cmp_i.ifc_ok ? lpm_pkg::ST_TTL_EXPIRED : lpm_pkg::ST_NO_ROUTE;
              ifc_q    <= '0;
              hop_q    <= '0;
              nttl_q   <= '0;
            end else begin
              status_q <= lpm_pkg::ST_FORWARDED;
              ifc_q    <= rdata_i.ifc;
              hop_q    <= rdata_i.hop_valid ? rdata_i.hop : key_q.prefix;
              nttl_q   <= ttl_q - lpm_pkg::TTL_W'(1);
            end
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_SCAN;
          end
        end
        S_PLACE: begin
          if (count_q == CW'(TABLE_DEPTH)) begin
            done_q   <= 1'b1;
            status_q <= lpm_pkg::ST_FULL;
            ifc_q    <= '0;
            hop_q    <= '0;
            nttl_q   <= '0;
            state_q  <= S_IDLE;
          end else begin
            idx_q   <= count_q;
            state_q <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (idx_q == pos_q) begin
            count_q  <= count_q + CW'(1);
            done_q   <= 1'b1;
            status_q <= lpm_pkg::ST_ADDED;
            ifc_q    <= '0;
            hop_q    <= '0;
            nttl_q   <= '0;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_MOVE_WR;
          end
        end
        S_MOVE_WR: begin
          idx_q   <= idx_dec;
          state_q <= S_MOVE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_interface_o = ifc_q;
  assign out_hop_o       = hop_q;
  assign new_ttl_o       = nttl_q;
  assign key_o           = key_q;

endmodule

// ===== hdl/lpm_checker.sv =====
// Port-level checker for the router top level, with its bind.
`include "longest_prefix_match_router_top_defines.svh"

module lpm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic [lpm_pkg::STATUS_W-1:0]  status_o,
  input logic [lpm_pkg::IFC_W-1:0]     out_interface_o,
  input logic [lpm_pkg::ADDR_W-1:0]    out_hop_o,
  input logic [lpm_pkg::TTL_W-1:0]     new_ttl_o
);

  `LPM_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted transaction did not raise busy")
  `LPM_ASSERT_NOW(a_done_idle, done_o, !busy_o, "result strobe while busy")
  `LPM_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  `LPM_ASSERT_NOW(a_status_code, done_o, status_o <= lpm_pkg::ST_TTL_EXPIRED, "undefined status code")
  `LPM_ASSERT_NOW(a_zero_fields, done_o && status_o != lpm_pkg::ST_FORWARDED, out_interface_o == '0 && out_hop_o == '0 && new_ttl_o == '0, "nonzero fields on non-forward result")

endmodule

bind longest_prefix_match_router_top lpm_checker u_lpm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .status_o        (status_o),
  .out_interface_o (out_interface_o),
  .out_hop_o       (out_hop_o),
  .new_ttl_o       (new_ttl_o)
);

// ===== dv/lpm_route_scoreboard_pkg.sv =====
// Route table predictor and result scoreboard for the prefix match router bench.
`timescale 1ns / 1ps
package lpm_route_scoreboard_pkg;
  import lpm_pkg::*;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              hop_valid;
    logic [ADDR_W-1:0] hop;
    logic [IFC_W-1:0]  ifc;
    logic [TTL_W-1:0]  ttl;
  } request_t;

  typedef struct {
    status_e           status;
    logic [IFC_W-1:0]  ifc;
    logic [ADDR_W-1:0] hop;
    logic [TTL_W-1:0]  ttl;
  } reply_t;

  class route_table_scoreboard;
    entry_t      routes[$];
    reply_t      expected_replies[$];
    int unsigned mismatches = 0;
    int unsigned status_hits[6];

    // High-order ones for a prefix length; anything past 32 keeps every bit.
    function logic [ADDR_W-1:0] prefix_mask(logic [LEN_W-1:0] len);
      if (len == 0) return '0;
      if (len >= MAX_LEN) return '1;
      return {ADDR_W{1'b1}} << (ADDR_W - len);
    endfunction

    // Insert ahead of the first shorter entry; equal lengths keep arrival order.
    function status_e insert_route(request_t r);
      entry_t e;
      int     pos;
      e.prefix    = r.addr;
      e.length    = (r.len > MAX_LEN) ? MAX_LEN : r.len;
      e.hop_valid = r.hop_valid;
      e.hop       = r.hop_valid ? r.hop : '0;
      e.ifc       = r.ifc;
      pos = routes.size();
      for (int i = 0; i < routes.size(); i++) begin
        if (routes[i] == e) return ST_DUPLICATE;
        if (routes[i].length < e.length) begin
          pos = i;
          break;
        end
      end
      if (routes.size() >= TABLE_DEPTH_DEF) return ST_FULL;
      routes.insert(pos, e);
      return ST_ADDED;
    endfunction

    function reply_t look_up(request_t r);
      reply_t rep;
      rep.status = ST_NO_ROUTE;
      rep.ifc    = '0;
      rep.hop    = '0;
      rep.ttl    = '0;
      for (int i = 0; i < routes.size(); i++) begin
        if ((r.addr & prefix_mask(routes[i].length)) != routes[i].prefix) continue;
        if (routes[i].ifc >= NUM_INTERFACES_DEF) break;
        if (r.ttl < TTL_MIN_FWD) begin
          rep.status = ST_TTL_EXPIRED;
        end else begin
          rep.status = ST_FORWARDED;
          rep.ifc    = routes[i].ifc;
          rep.hop    = routes[i].hop_valid ? routes[i].hop : r.addr;
          rep.ttl    = r.ttl - 1'b1;
        end
        break;
      end
      return rep;
    endfunction

    function void note_request(request_t r);
      reply_t rep;
      if (r.op == OP_ADD) begin
        rep.status = insert_route(r);
        rep.ifc    = '0;
        rep.hop    = '0;
        rep.ttl    = '0;
      end else begin
        rep = look_up(r);
      end
      expected_replies = {expected_replies, rep};
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [IFC_W-1:0] ifc,
                              logic [ADDR_W-1:0] hop, logic [TTL_W-1:0] ttl);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("status: expected no result, got %0d", status);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      status_hits[int'(want.status)]++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (ifc !== want.ifc) begin
        $error("out_interface: expected %0d, got %0d", want.ifc, ifc);
        mismatches++;
      end
      if (hop !== want.hop) begin
        $error("out_hop: expected %08h, got %08h", want.hop, hop);
        mismatches++;
      end
      if (ttl !== want.ttl) begin
        $error("new_ttl: expected %0d, got %0d", want.ttl, ttl);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

endpackage

// ===== dv/longest_prefix_match_router_top_test.sv =====
// Self-checking bench for the longest prefix match router: table adds and lookups.
`timescale 1ns / 1ps
module longest_prefix_match_router_top_test;
  import lpm_pkg::*;
  import lpm_route_scoreboard_pkg::*;

  localparam int unsigned     RANDOM_ITEMS = 1330;
  // Longest add: scan and shift the whole table, plus a few cycles of margin.
  localparam int unsigned     DRAIN_CYCLES = 4 * TABLE_DEPTH_DEF + 16;
  localparam longint unsigned CYCLE_LIMIT  = 1_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                operation_i;
  logic [ADDR_W-1:0]   address_i;
  logic [LEN_W-1:0]    prefix_len_i;
  logic                hop_valid_i;
  logic [ADDR_W-1:0]   hop_address_i;
  logic [IFC_W-1:0]    interface_index_i;
  logic [TTL_W-1:0]    time_to_live_i;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [IFC_W-1:0]    out_interface_o;
  logic [ADDR_W-1:0]   out_hop_o;
  logic [TTL_W-1:0]    new_ttl_o;

  route_table_scoreboard scoreboard;
  request_t              issued_adds[$];  // every add sent, source of repeats and lookups
  longint unsigned       cycle_count;
  int unsigned           sent_count;

  longest_prefix_match_router_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .prefix_len_i      (prefix_len_i),
    .hop_valid_i       (hop_valid_i),
    .hop_address_i     (hop_address_i),
    .interface_index_i (interface_index_i),
    .time_to_live_i    (time_to_live_i),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .status_o          (status_o),
    .out_interface_o   (out_interface_o),
    .out_hop_o         (out_hop_o),
    .new_ttl_o         (new_ttl_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run; the limit sits several times above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, scoreboard.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Results cannot be held off: grab each one on the edge that closes its strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      scoreboard.check_reply(status_o, out_interface_o, out_hop_o, new_ttl_o);
    end
  end

  // Build an add; the TTL field is unused here, so fill it with noise.
  function automatic request_t make_add(logic [ADDR_W-1:0] prefix, logic [LEN_W-1:0] len,
                                        logic hv, logic [ADDR_W-1:0] hop,
                                        logic [IFC_W-1:0] ifc);
    request_t r;
    r.op        = OP_ADD;
    r.addr      = prefix;
    r.len       = len;
    r.hop_valid = hv;
    r.hop       = hop;
    r.ifc       = ifc;
    r.ttl       = TTL_W'($urandom);
    return r;
  endfunction

  // Build a lookup; the add-only fields carry noise the block must ignore.
  function automatic request_t make_route(logic [ADDR_W-1:0] dest, logic [TTL_W-1:0] ttl);
    request_t r;
    r.op        = OP_ROUTE;
    r.addr      = dest;
    r.len       = LEN_W'($urandom);
    r.hop_valid = 1'($urandom);
    r.hop       = ADDR_W'($urandom);
    r.ifc       = IFC_W'($urandom);
    r.ttl       = ttl;
    return r;
  endfunction

  // Drive one transaction and hold it until the block takes it. Called on a rising
  // edge; returns on the edge that accepted it, with start still high so that a
  // back-to-back transaction needs no second assignment in the same step.
  task automatic issue(request_t r, bit allow_gap);
    int unsigned gap;
    gap = allow_gap ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      // Half the time let the gap fall after the block went idle, not while busy.
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy_o);
      end
      repeat (gap) @(posedge clk_i);
    end
    start_i           <= 1'b1;
    operation_i       <= r.op;
    address_i         <= r.addr;
    prefix_len_i      <= r.len;
    hop_valid_i       <= r.hop_valid;
    hop_address_i     <= r.hop;
    interface_index_i <= r.ifc;
    time_to_live_i    <= r.ttl;
    do @(posedge clk_i); while (busy_o);
    scoreboard.note_request(r);
    if (r.op == OP_ADD) issued_adds = {issued_adds, r};
    sent_count++;
  endtask

  initial begin
    request_t          req;
    request_t          base;
    logic [ADDR_W-1:0] mask;
    logic [LEN_W-1:0]  len;
    bit                calm;

    scoreboard        = new();
    cycle_count       = 0;
    sent_count        = 0;
    rst_ni            <= 1'b0;
    start_i           <= 1'b0;
    operation_i       <= OP_ADD;
    address_i         <= '0;
    prefix_len_i      <= '0;
    hop_valid_i       <= 1'b0;
    hop_address_i     <= '0;
    interface_index_i <= '0;
    time_to_live_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, default route, ordering, clamping and duplicates.
    issue(make_route(32'h0A01_0203, 8'd64), 1'b1);                    // empty table
    issue(make_add(32'h0000_0000, 6'd0, 1'b0, 32'h0, 4'd0), 1'b1);     // default route
    issue(make_route(32'hCB00_7109, 8'd0), 1'b1);                     // ttl zero
    issue(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0101, 4'd15), 1'b1);
    issue(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0101, 4'd15), 1'b1); // repeat
    issue(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0102, 4'd15), 1'b1); // same length
    issue(make_add(32'h0A01_0203, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd3), 1'b1); // clamp to 32
    issue(make_add(32'h0A01_0203, 6'd32, 1'b1, 32'hFFFF_FFFF, 4'd3), 1'b1); // now a repeat
    issue(make_add(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h1234_5678, 4'd7), 1'b1);
    issue(make_add(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 4'd7), 1'b1); // direct repeat
    issue(make_add(32'h0A00_00FF, 6'd8, 1'b1, 32'h0101_0101, 4'd9), 1'b1);  // never matches
    issue(make_add(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 4'd5), 1'b1);
    issue(make_add(32'h8000_0000, 6'd1, 1'b1, 32'h0000_0000, 4'd12), 1'b1); // zero next hop
    issue(make_route(32'h0A01_0203, 8'd255), 1'b1);                   // host route
    issue(make_route(32'h0A01_0909, 8'd2), 1'b1);                     // direct, ttl to 1
    issue(make_route(32'h0A09_0909, 8'd1), 1'b1);                     // ttl expires
    issue(make_route(32'hFFFF_FFFF, 8'd128), 1'b1);
    issue(make_route(32'h0000_0000, 8'd3), 1'b1);                     // default only
    issue(make_route(32'h8000_0001, 8'd200), 1'b1);
    issue(make_add(32'h0000_0000, 6'd0, 1'b0, 32'hFFFF_FFFF, 4'd0), 1'b1);  // repeat
    issue(make_route(32'h0A00_00FF, 8'd9), 1'b0);

    // Random: a quarter adds (fresh, or repeats of earlier routes, some altered),
    // the rest lookups aimed mostly inside stored prefixes. The table fills early,
    // after which adds exercise the full and duplicate paths.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 50) % 4) == 3;  // every fourth stretch of 50 runs back to back
      if ($urandom_range(0, 99) < 25) begin
        if (issued_adds.size() != 0 && $urandom_range(0, 2) == 0) begin
          req = issued_adds[$urandom_range(0, issued_adds.size() - 1)];
          req.ttl = TTL_W'($urandom);
          case ($urandom_range(0, 3))
            0: ;                                  // exact repeat
            1: req.hop = ADDR_W'($urandom);       // still a repeat when direct
            2: req.ifc = IFC_W'($urandom);
            default: begin
              if (req.len >= MAX_LEN) req.len = LEN_W'($urandom_range(32, 63));
            end
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0:       len = LEN_W'($urandom_range(0, 63));
            1:       len = LEN_W'(8 * $urandom_range(0, 4));
            default: len = LEN_W'($urandom_range(16, 32));
          endcase
          req = make_add(ADDR_W'($urandom), len, 1'($urandom), ADDR_W'($urandom),
                         IFC_W'($urandom));
          // Most prefixes are clean; the rest keep stray bits below the length.
          if ($urandom_range(0, 3) != 0) req.addr &= scoreboard.prefix_mask(len);
        end
      end else begin
        if (issued_adds.size() != 0 && $urandom_range(0, 4) != 0) begin
          base = issued_adds[$urandom_range(0, issued_adds.size() - 1)];
          mask = scoreboard.prefix_mask(base.len);
          req  = make_route((base.addr & mask) | (ADDR_W'($urandom) & ~mask), 8'd0);
        end else begin
          req = make_route(ADDR_W'($urandom), 8'd0);
        end
        req.ttl = ($urandom_range(0, 5) == 0) ? TTL_W'($urandom_range(0, 2)) : TTL_W'($urandom);
      end
      issue(req, !calm);
    end
    start_i <= 1'b0;

    // Drain outstanding results, then give the block one full add time to misbehave.
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions in %0d cycles: %0d added, %0d duplicate, %0d table full",
             sent_count, cycle_count, scoreboard.status_hits[ST_ADDED],
             scoreboard.status_hits[ST_DUPLICATE], scoreboard.status_hits[ST_FULL]);
    $display("Lookups: %0d forwarded, %0d no route, %0d ttl expired; %0d routes stored",
             scoreboard.status_hits[ST_FORWARDED], scoreboard.status_hits[ST_NO_ROUTE],
             scoreboard.status_hits[ST_TTL_EXPIRED], scoreboard.routes.size());
    if (scoreboard.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lpm_pkg.sv
hdl/lpm_table.sv
hdl/lpm_cmp.sv
hdl/lpm_seq.sv
hdl/longest_prefix_match_router_top.sv
hdl/lpm_checker.sv
dv/lpm_route_scoreboard_pkg.sv
dv/longest_prefix_match_router_top_test.sv
